// ----- design/mm3_pkg.sv -----
`default_nettype none

package mm3_pkg;

    // Mixing constants
    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

    // Bytes in one full word
    localparam logic [2:0] WORD_BYTES = 3'd4;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Input request
    typedef struct packed {
        logic [31:0] seed;
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic        last_word;
    } t_req;

    // Result
    typedef struct packed {
        logic [31:0] hash_value;
        logic [31:0] message_length;
    } t_res;

    // How the back end treats a word
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_TAIL,
        KIND_FULL
    } t_kind;

    // Classified word, front to back
    typedef struct packed {
        logic [31:0] seed;
        logic [31:0] word;
        t_kind       kind;
        logic [2:0]  add_bytes;
        logic        first;
        logic        last;
    } t_job;

    // Back-end sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX2,
        ST_UPD,
        ST_FIN1,
        ST_FIN2,
        ST_FIN3
    } t_back_state;

endpackage

`default_nettype wire

// ----- design/mm3_front.sv -----
`default_nettype none

module mm3_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire mm3_pkg::t_req i_req,
    output logic               o_job_wr,
    output mm3_pkg::t_job      o_job,
    input  wire logic          i_job_full
);

    logic       r_in_msg;
    logic       n_in_msg;
    logic [2:0] nvalid;
    logic [31:0] tail_mask;

    assign full     = i_job_full;
    assign o_job_wr = push && !i_job_full;

    // Saturate valid count to a full word
    assign nvalid = (i_req.valid_bytes > mm3_pkg::WORD_BYTES) ? mm3_pkg::WORD_BYTES
                                                              : i_req.valid_bytes;

    // Keep only the valid bytes of a partial word
    always_comb begin
        case (nvalid)
            3'd1:    tail_mask = 32'h0000_00ff;
            3'd2:    tail_mask = 32'h0000_ffff;
            3'd3:    tail_mask = 32'h00ff_ffff;
            default: tail_mask = 32'hffff_ffff;
        endcase
    end

    // Classify the word
    always_comb begin
        o_job.seed  = i_req.seed;
        o_job.first = !r_in_msg;
        o_job.last  = i_req.last_word;
        if (!i_req.last_word || nvalid == mm3_pkg::WORD_BYTES) begin
            o_job.kind      = mm3_pkg::KIND_FULL;
            o_job.add_bytes = mm3_pkg::WORD_BYTES;
            o_job.word      = i_req.data_word;
        end else if (nvalid != 3'd0) begin
            o_job.kind      = mm3_pkg::KIND_TAIL;
            o_job.add_bytes = nvalid;
            o_job.word      = i_req.data_word & tail_mask;
        end else begin
            o_job.kind      = mm3_pkg::KIND_NONE;
            o_job.add_bytes = 3'd0;
            o_job.word      = i_req.data_word;
        end
    end

    // Message open flag: a last word closes the message
    assign n_in_msg = o_job_wr ? !i_req.last_word : r_in_msg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
        end else begin
            r_in_msg <= n_in_msg;
        end
    end

endmodule

`default_nettype wire

// ----- design/mm3_queue.sv -----
`default_nettype none

module mm3_queue #(
    parameter int DEPTH = mm3_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire mm3_pkg::t_job i_wdata,
    output logic               o_full,
    input  wire logic          i_rd,
    output mm3_pkg::t_job      o_rdata,
    output logic               o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mm3_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr;
    logic             do_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_rd_ptr_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_rd && !do_wr |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count did not drop on read");
`endif

endmodule

`default_nettype wire

// ----- design/mm3_back.sv -----
`default_nettype none

module mm3_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_empty,
    input  wire mm3_pkg::t_job i_job,
    output logic               o_job_rd,
    input  wire logic          pop,
    output logic               empty,
    output mm3_pkg::t_res      o_res
);

    mm3_pkg::t_back_state r_state;
    mm3_pkg::t_back_state n_state;
    mm3_pkg::t_job        r_job;
    mm3_pkg::t_res        r_out;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 out_load;
    logic [31:0] r_k;
    logic [31:0] r_h;
    logic [31:0] r_total;
    logic [31:0] r_f;

    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] h_base;
    logic [31:0] t_base;
    logic [31:0] h_x;
    logic [31:0] h_rot;
    logic [31:0] h_new;
    logic [31:0] t_new;
    logic [31:0] f_in;
    logic [31:0] f1;
    logic [31:0] f_sh13;
    logic [31:0] f2;
    logic [31:0] hash;

    assign empty = !r_out_valid;
    assign o_res = r_out;

    // Block mix: multiply, rotate by 15, multiply
    assign k1 = i_job.word * mm3_pkg::MIX_C1;
    assign k2 = {r_k[16:0], r_k[31:17]} * mm3_pkg::MIX_C2;

    // Running-hash update; first word of a message starts from the seed
    assign h_base = r_job.first ? r_job.seed : r_h;
    assign t_base = r_job.first ? 32'd0 : r_total;
    assign h_x    = (r_job.kind == mm3_pkg::KIND_NONE) ? h_base : (h_base ^ r_k);
    assign h_rot  = {h_x[18:0], h_x[31:19]};
    assign h_new  = (r_job.kind == mm3_pkg::KIND_FULL)
                  ? ({h_rot[29:0], 2'b00} + h_rot + mm3_pkg::MIX_ADD) : h_x;
    assign t_new  = t_base + {29'd0, r_job.add_bytes};

    // Finalizer, one multiply per step
    assign f_in   = r_h ^ r_total;
    assign f1     = (f_in ^ {16'd0, f_in[31:16]}) * mm3_pkg::FIN_M1;
    assign f_sh13 = r_f ^ {13'd0, r_f[31:13]};
    assign f2     = f_sh13 * mm3_pkg::FIN_M2;
    assign hash   = r_f ^ {16'd0, r_f[31:16]};

    // Sequencer
    always_comb begin
        n_state  = r_state;
        o_job_rd = 1'b0;
        out_load = 1'b0;
        case (r_state)
            mm3_pkg::ST_IDLE: begin
                if (!i_job_empty) begin
                    o_job_rd = 1'b1;
                    n_state  = mm3_pkg::ST_MIX2;
                end
            end
            mm3_pkg::ST_MIX2: begin
                n_state = mm3_pkg::ST_UPD;
            end
            mm3_pkg::ST_UPD: begin
                n_state = r_job.last ? mm3_pkg::ST_FIN1 : mm3_pkg::ST_IDLE;
            end
            mm3_pkg::ST_FIN1: begin
                n_state = mm3_pkg::ST_FIN2;
            end
            mm3_pkg::ST_FIN2: begin
                n_state = mm3_pkg::ST_FIN3;
            end
            mm3_pkg::ST_FIN3: begin
                if (!r_out_valid || pop) begin
                    out_load = 1'b1;
                    n_state  = mm3_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mm3_pkg::ST_IDLE;
            end
        endcase
    end

    // Result register: cleared by pop, refilled by the finalizer
    assign n_out_valid = out_load || (r_out_valid && !pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mm3_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            mm3_pkg::ST_IDLE: begin
                r_job <= i_job;
                r_k   <= k1;
            end
            mm3_pkg::ST_MIX2: begin
                r_k <= k2;
            end
            mm3_pkg::ST_UPD: begin
                r_h     <= h_new;
                r_total <= t_new;
            end
            mm3_pkg::ST_FIN1: begin
                r_f <= f1;
            end
            mm3_pkg::ST_FIN2: begin
                r_f <= f2;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out.hash_value     <= hash;
            r_out.message_length <= r_total;
        end
    end

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !pop |=> r_out_valid && $stable(r_out))
        else $error("waiting result changed before pop");

    a_rd_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_rd |-> r_state == mm3_pkg::ST_IDLE && !i_job_empty)
        else $error("job taken outside idle");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mm3_pkg::ST_FIN3 && !r_out_valid |=> r_out_valid)
        else $error("finalized hash not loaded");
`endif

endmodule

`default_nettype wire

// ----- design/murmur3_32_stream_hash_top.sv -----
// A word goes through the queue, then back-end states IDLE, MIX2 and UPD; a last
// word then also passes FIN1, FIN2 and FIN3; FIN3 loads o_res when it is free.
//   Only IDLE takes a new word; mix and finalizer do one multiply per cycle.
// By default a 2-entry queue lets the front take words while the back end works.
// Reset: synchronous, active low; clears the queue, sequencer and result valid.
`default_nettype none

module murmur3_32_stream_hash_top #(
    parameter int QUEUE_DEPTH = mm3_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire mm3_pkg::t_req i_req,
    output logic               empty,
    input  wire logic          pop,
    output mm3_pkg::t_res      o_res
);

    logic          job_wr;
    logic          job_full;
    logic          job_rd;
    logic          job_empty;
    mm3_pkg::t_job job_in;
    mm3_pkg::t_job job_out;

    // Accept and classify words
    mm3_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_req      (i_req),
        .o_job_wr   (job_wr),
        .o_job      (job_in),
        .i_job_full (job_full)
    );

    // Decoupling queue
    mm3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_wr),
        .i_wdata (job_in),
        .o_full  (job_full),
        .i_rd    (job_rd),
        .o_rdata (job_out),
        .o_empty (job_empty)
    );

    // Mix, update and finalize
    mm3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_rd    (job_rd),
        .pop         (pop),
        .empty       (empty),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire
